### design/mpc_pkg.sv
// Shared constants for the Mandelbrot pixel colorizer.
package mpc_pkg;

	// Alpha byte placed in the low byte of every color word
	localparam logic [7:0] ALPHA = 8'hFF;

	// Bernstein weights scaled by 255: 255*9, 255*15, 255*8.5*2
	localparam logic [15:0] RED_COEF   = 16'd2295;
	localparam logic [15:0] GREEN_COEF = 16'd3825;
	localparam logic [15:0] BLUE_COEF  = 16'd4335;

	// Polynomial accumulator geometry: 3 chunks of 32 bits
	localparam int ACC_W    = 96;
	localparam int CHUNK_W  = 32;
	localparam int FACTOR_W = 16;

endpackage

### design/mandelbrot_pixel_colorizer_core.sv
// Top level of the Mandelbrot escape-time pixel colorizer.
//
// Command channel: drive c_real, c_imag (signed fixed point, COORD_FRAC_BITS
// fraction bits) and dither with start high; the transfer happens at the edge
// where start is high and busy is low. busy stays high until the result goes out.
// Result channel: color_word is valid for the single cycle in which done is
// high; the receiver must take it then.
// Flow from transfer to result: each iteration runs on one shared multiplier
// (zr^2, zi^2 and zr*zi in turn, then the z update) until a component
// reaches two or |z|^2 reaches four; a reciprocal multiply then forms t,
// and the chunked 32x16 multiplier builds the three polynomials.
// Points that hit MAX_ITER skip straight to a black result.
// One pixel is in flight at a time; the next transfer can start the cycle
// after done.
// Reset clears all sequencers and busy; no result is pending after reset.
module mandelbrot_pixel_colorizer_core #(
	parameter int MAX_ITER        = 256,
	parameter int COORD_FRAC_BITS = 28
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] c_real,
	input  logic signed [31:0] c_imag,
	input  logic [7:0]         dither,
	output logic               done,
	output logic [31:0]        color_word
);

	localparam int CW = $clog2(MAX_ITER + 1);

	logic          busy_q;
	logic [7:0]    dither_q;
	logic          accept;
	logic          esc_done;
	logic [CW-1:0] esc_count;
	logic          shade_done;

	assign accept = start & ~busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			dither_q <= '0;
		end else begin
			if (accept) begin
				busy_q   <= 1'b1;
				dither_q <= dither;
			end else if (shade_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	mpc_escape #(
		.MAX_ITER  (MAX_ITER),
		.FRAC_BITS (COORD_FRAC_BITS)
	) u_escape (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.c_real (c_real),
		.c_imag (c_imag),
		.done   (esc_done),
		.count  (esc_count)
	);

	mpc_shade #(
		.MAX_ITER (MAX_ITER)
	) u_shade (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (esc_done),
		.count      (esc_count),
		.dither     (dither_q),
		.done       (shade_done),
		.color_word (color_word)
	);

	assign busy = busy_q;
	assign done = shade_done;

endmodule

### design/mpc_escape.sv
// Escape-time iteration z = z*z + c on one shared magnitude multiplier.
module mpc_escape #(
	parameter int MAX_ITER  = 256,
	parameter int FRAC_BITS = 28
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [31:0]                c_real,
	input  logic signed [31:0]                c_imag,
	output logic                              done,
	output logic [$clog2(MAX_ITER + 1)-1:0]   count
);

	localparam int CW = $clog2(MAX_ITER + 1);
	localparam int MW = FRAC_BITS + 1;          // operand magnitude after escape test
	localparam int PW = 2 * MW;                 // exact product
	localparam int SW = FRAC_BITS + 2;          // product after fraction shift
	localparam int ZW = ((FRAC_BITS + 4 > 32) ? FRAC_BITS + 4 : 32) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQ_R,
		S_SQ_I,
		S_CROSS,
		S_UPDATE
	} state_t;

	state_t                 state_q;
	logic signed [ZW-1:0]   zr_q, zi_q;
	logic signed [31:0]     cr_q, ci_q;
	logic [SW-1:0]          sr_q, si_q;
	logic [PW-1:0]          prod_q;
	logic                   neg_q;
	logic [CW-1:0]          count_q;
	logic                   done_q;

	logic [ZW-1:0]          zr_mag, zi_mag;
	logic                   escaped;
	logic [MW-1:0]          mul_a, mul_b;
	logic [PW-1:0]          prod_d;
	logic [SW-1:0]          shifted;
	logic [SW:0]            mag_sum;
	logic signed [ZW-1:0]   p_ext, p_signed, zr_next, zi_next;

	assign zr_mag  = zr_q[ZW-1] ? ZW'(-zr_q) : ZW'(zr_q);
	assign zi_mag  = zi_q[ZW-1] ? ZW'(-zi_q) : ZW'(zi_q);
	assign escaped = (|zr_mag[ZW-1:FRAC_BITS+1]) | (|zi_mag[ZW-1:FRAC_BITS+1]);

	// operand select for the shared multiplier
	always_comb begin
		unique case (state_q)
			S_SQ_I: begin
				mul_a = zi_mag[MW-1:0];
				mul_b = zi_mag[MW-1:0];
			end
			S_CROSS: begin
				mul_a = zr_mag[MW-1:0];
				mul_b = zi_mag[MW-1:0];
			end
			default: begin
				mul_a = zr_mag[MW-1:0];
				mul_b = zr_mag[MW-1:0];
			end
		endcase
	end

	assign prod_d  = PW'(mul_a) * PW'(mul_b);
	assign shifted = prod_q[PW-1:FRAC_BITS];
	assign mag_sum = {1'b0, sr_q} + {1'b0, shifted};

	assign p_ext    = signed'({{(ZW-SW){1'b0}}, shifted});
	assign p_signed = neg_q ? -p_ext : p_ext;
	assign zr_next  = signed'({{(ZW-SW){1'b0}}, sr_q}) - signed'({{(ZW-SW){1'b0}}, si_q})
		+ signed'({{(ZW-32){cr_q[31]}}, cr_q});
	assign zi_next  = (p_signed <<< 1) + signed'({{(ZW-32){ci_q[31]}}, ci_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			zr_q    <= '0;
			zi_q    <= '0;
			cr_q    <= '0;
			ci_q    <= '0;
			sr_q    <= '0;
			si_q    <= '0;
			prod_q  <= '0;
			neg_q   <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cr_q    <= c_real;
						ci_q    <= c_imag;
						zr_q    <= '0;
						zi_q    <= '0;
						count_q <= '0;
						state_q <= S_SQ_R;
					end
				end
				S_SQ_R: begin
					if (escaped) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						prod_q  <= prod_d;
						neg_q   <= zr_q[ZW-1] ^ zi_q[ZW-1];
						state_q <= S_SQ_I;
					end
				end
				S_SQ_I: begin
					sr_q    <= shifted;
					prod_q  <= prod_d;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					// |z|^2 >= 4 means the sum reaches bit SW
					if (mag_sum[SW]) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						si_q    <= shifted;
						prod_q  <= prod_d;
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					zr_q    <= zr_next;
					zi_q    <= zi_next;
					count_q <= count_q + 1'b1;
					if (count_q + 1'b1 == CW'(MAX_ITER)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SQ_R;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign count = count_q;

endmodule

### design/mpc_shade.sv
// Escape count to color: reciprocal multiply for t, then chunked Bernstein products.
module mpc_shade #(
	parameter int MAX_ITER = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [$clog2(MAX_ITER + 1)-1:0]   count,
	input  logic [7:0]                        dither,
	output logic                              done,
	output logic [31:0]                       color_word
);

	localparam int CW = $clog2(MAX_ITER + 1);
	localparam int AW = mpc_pkg::ACC_W;
	localparam int KW = mpc_pkg::CHUNK_W;
	localparam int FW = mpc_pkg::FACTOR_W;

	// t = (count*256 + dither) * 256 / MAX_ITER, formed as a product with
	// ceil(2^40 / MAX_ITER); exact while count < MAX_ITER <= 4096
	localparam int RECIP_SH = 32;
	localparam logic [AW-1:0] RECIP = AW'(((64'd1 << (RECIP_SH + 8)) + 64'(MAX_ITER) - 64'd1)
		/ 64'(MAX_ITER));
	localparam logic [AW-1:0] RECIP_X256 = RECIP << 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RECIP,
		S_SETUP,
		S_POLY,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} chan_t;

	state_t          state_q;
	chan_t           chan_q;
	logic [CW-1:0]   count_q;
	logic [7:0]      dith_q;
	logic            pass_q;     // 0: count * 256R, 1: dither * R
	logic [FW-1:0]   t_q, u_q;
	logic [AW-1:0]   src_q, dst_q;
	logic [1:0]      fac_q, chunk_q;
	logic [7:0]      red_q, green_q, blue_q;
	logic            done_q;
	logic [31:0]     color_q;

	logic [1:0]              t_pow;
	logic [FW-1:0]           factor;
	logic [KW-1:0]           chunk;
	logic [KW+FW-1:0]        prod;
	logic [AW-1:0]           addend, acc_sum;

	// red t^3 u, green t^2 u^2, blue t u^3
	always_comb begin
		unique case (chan_q)
			CH_RED:   t_pow = 2'd3;
			CH_GREEN: t_pow = 2'd2;
			default:  t_pow = 2'd1;
		endcase
	end

	always_comb begin
		if (state_q == S_RECIP) begin
			factor = pass_q ? FW'(dith_q) : FW'(count_q);
		end else begin
			factor = (fac_q < t_pow) ? t_q : u_q;
		end
	end

	always_comb begin
		unique case (chunk_q)
			2'd0:    chunk = src_q[KW-1:0];
			2'd1:    chunk = src_q[2*KW-1:KW];
			default: chunk = src_q[3*KW-1:2*KW];
		endcase
	end

	assign prod = (KW + FW)'(chunk) * (KW + FW)'(factor);

	always_comb begin
		unique case (chunk_q)
			2'd0:    addend = AW'(prod);
			2'd1:    addend = AW'({prod, {KW{1'b0}}});
			default: addend = {prod[AW-2*KW-1:0], {(2*KW){1'b0}}};
		endcase
	end

	assign acc_sum = dst_q + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			chan_q   <= CH_RED;
			count_q  <= '0;
			dith_q   <= '0;
			pass_q   <= 1'b0;
			t_q      <= '0;
			u_q      <= '0;
			src_q    <= '0;
			dst_q    <= '0;
			fac_q    <= '0;
			chunk_q  <= '0;
			red_q    <= '0;
			green_q  <= '0;
			blue_q   <= '0;
			done_q   <= 1'b0;
			color_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						count_q <= count;
						dith_q  <= dither;
						src_q   <= RECIP_X256;
						dst_q   <= '0;
						chunk_q <= '0;
						pass_q  <= 1'b0;
						if (count == CW'(MAX_ITER)) begin
							// t clamps to one: every channel is zero
							red_q   <= '0;
							green_q <= '0;
							blue_q  <= '0;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_RECIP;
						end
					end
				end
				S_RECIP: begin
					if (chunk_q == 2'd2) begin
						chunk_q <= '0;
						dst_q   <= acc_sum;
						src_q   <= RECIP;
						pass_q  <= 1'b1;
						if (pass_q) begin
							t_q     <= acc_sum[RECIP_SH+FW-1:RECIP_SH];
							state_q <= S_SETUP;
						end
					end else begin
						dst_q   <= acc_sum;
						chunk_q <= chunk_q + 1'b1;
					end
				end
				S_SETUP: begin
					u_q     <= -t_q;
					src_q   <= AW'(mpc_pkg::RED_COEF);
					dst_q   <= '0;
					fac_q   <= '0;
					chunk_q <= '0;
					chan_q  <= CH_RED;
					if (t_q == '0) begin
						red_q   <= '0;
						green_q <= '0;
						blue_q  <= '0;
						state_q <= S_FINISH;
					end else begin
						state_q <= S_POLY;
					end
				end
				S_POLY: begin
					if (chunk_q == 2'd2) begin
						chunk_q <= '0;
						dst_q   <= '0;
						src_q   <= acc_sum;
						fac_q   <= fac_q + 1'b1;
						if (fac_q == 2'd3) begin
							fac_q <= '0;
							unique case (chan_q)
								CH_RED: begin
									red_q  <= acc_sum[71:64];
									src_q  <= AW'(mpc_pkg::GREEN_COEF);
									chan_q <= CH_GREEN;
								end
								CH_GREEN: begin
									green_q <= acc_sum[71:64];
									src_q   <= AW'(mpc_pkg::BLUE_COEF);
									chan_q  <= CH_BLUE;
								end
								default: begin
									blue_q  <= acc_sum[72:65];
									state_q <= S_FINISH;
								end
							endcase
						end
					end else begin
						dst_q   <= acc_sum;
						chunk_q <= chunk_q + 1'b1;
					end
				end
				S_FINISH: begin
					done_q  <= 1'b1;
					color_q <= {red_q, blue_q, green_q, mpc_pkg::ALPHA};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign color_word = color_q;

endmodule

### design/mpc_checker.sv
// Port-level checks for the colorizer top level, bound to every instance.
module mpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] color_word
);

	// every result carries the fixed alpha byte
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> color_word[7:0] == mpc_pkg::ALPHA)
		else $error("color word without alpha");

	// a result only comes out of an open transfer
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result with no pixel in flight");

	// a transfer makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("transfer did not start work");

	// busy drops exactly after the result
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy held after result");

	a_fall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

endmodule

bind mandelbrot_pixel_colorizer_core mpc_checker u_mpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.color_word (color_word)
);
